[rtl/core/vsrt_pkg.sv]
// Shared types, constants and helpers for the vertex scale/rotate/translate core.
// Used by the core, its rotation stage and the testbench; depends on nothing.
`default_nettype none

package vsrt_pkg;

    localparam int unsigned CoordW  = 32;
    localparam int unsigned ScaleW  = 16;
    localparam int unsigned TrigW   = 16;
    localparam int unsigned WideW   = 49;
    localparam int unsigned CfgIdxW = 8;
    localparam int unsigned CfgDataW = 48;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [WideW-1:0]  wide_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SINCOS_X     = 8'd0,
        REG_SINCOS_Y     = 8'd1,
        REG_SINCOS_Z     = 8'd2,
        REG_SCALE_XYZ    = 8'd3,
        REG_OFFSET_X     = 8'd4,
        REG_OFFSET_Y     = 8'd5,
        REG_OFFSET_Z     = 8'd6,
        REG_ROTATE_EN    = 8'd7
    } cfg_reg_t;

    localparam logic [31:0] SincosReset = 32'h0000_4000;
    localparam logic [47:0] ScaleReset  = 48'h0100_0100_0100;

    localparam wide_t SatMax = wide_t'(64'sd2147483647);
    localparam wide_t SatMin = wide_t'(-64'sd2147483648);

    // Clamp a wide signed intermediate to the 32-bit coordinate range.
    function automatic coord_t sat32(input wide_t v);
        coord_t r;
        if (v > SatMax)
        begin
            r = coord_t'(SatMax);
        end
        else if (v < SatMin)
        begin
            r = coord_t'(SatMin);
        end
        else
        begin
            r = coord_t'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/vertex_scale_rotate_translate_core.sv]
// Throughput: one vertex per cycle unless m_axis_tready is held low; each of the nine
// register stages holds one beat and takes a new one whenever it is empty or its
// successor moves on.
// Stages: scale product, scale clamp, three rotations of two stages each, translate.
// Reset (rst_n low, asynchronous) empties every stage and loads the identity transform.
// Depends on vsrt_pkg and vsrt_rot_stage.
`default_nettype none

module vertex_scale_rotate_translate_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration writes.
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [vsrt_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [vsrt_pkg::CfgDataW-1:0]   cfg_data,
    // Input vertices.
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [95:0]                     s_axis_tdata,  // pos_x, pos_y, pos_z
    // Transformed vertices.
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [95:0]                     m_axis_tdata   // out_x, out_y, out_z
);

    logic [31:0] sincos_x_reg, sincos_y_reg, sincos_z_reg;
    logic [47:0] scale_xyz_reg;
    logic [31:0] offset_x_reg, offset_y_reg, offset_z_reg;
    logic [2:0]  rotate_enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sincos_x_reg      <= vsrt_pkg::SincosReset;
            sincos_y_reg      <= vsrt_pkg::SincosReset;
            sincos_z_reg      <= vsrt_pkg::SincosReset;
            scale_xyz_reg     <= vsrt_pkg::ScaleReset;
            offset_x_reg      <= '0;
            offset_y_reg      <= '0;
            offset_z_reg      <= '0;
            rotate_enable_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vsrt_pkg::REG_SINCOS_X:  sincos_x_reg      <= cfg_data[31:0];
                vsrt_pkg::REG_SINCOS_Y:  sincos_y_reg      <= cfg_data[31:0];
                vsrt_pkg::REG_SINCOS_Z:  sincos_z_reg      <= cfg_data[31:0];
                vsrt_pkg::REG_SCALE_XYZ: scale_xyz_reg     <= cfg_data[47:0];
                vsrt_pkg::REG_OFFSET_X:  offset_x_reg      <= cfg_data[31:0];
                vsrt_pkg::REG_OFFSET_Y:  offset_y_reg      <= cfg_data[31:0];
                vsrt_pkg::REG_OFFSET_Z:  offset_z_reg      <= cfg_data[31:0];
                vsrt_pkg::REG_ROTATE_EN: rotate_enable_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Input fields.
    vsrt_pkg::coord_t pos_x, pos_y, pos_z;
    assign pos_x = s_axis_tdata[31:0];
    assign pos_y = s_axis_tdata[63:32];
    assign pos_z = s_axis_tdata[95:64];

    logic signed [15:0] kx, ky, kz;
    assign kx = scale_xyz_reg[15:0];
    assign ky = scale_xyz_reg[31:16];
    assign kz = scale_xyz_reg[47:32];

    // Stage 0: scale products.
    logic            v0_reg, r0;
    vsrt_pkg::wide_t px_reg, py_reg, pz_reg;
    vsrt_pkg::wide_t px_next, py_next, pz_next;

    // Stage 1: scale clamp.
    logic             v1_reg, r1;
    vsrt_pkg::coord_t sx_reg, sy_reg, sz_reg;

    // Rotation chain.
    logic             rx_in_ready, rx_valid, ry_in_ready, ry_valid, rz_in_ready, rz_valid;
    vsrt_pkg::coord_t rx_y, rx_z, rx_x;
    vsrt_pkg::coord_t ry_x, ry_z, ry_y;
    vsrt_pkg::coord_t rz_x, rz_y, rz_z;

    // Translate stage.
    logic             vt_reg, rt;
    vsrt_pkg::coord_t tx_reg, ty_reg, tz_reg;
    vsrt_pkg::coord_t tx_next, ty_next, tz_next;

    assign rt = !vt_reg || m_axis_tready;
    assign r1 = !v1_reg || rx_in_ready;
    assign r0 = !v0_reg || r1;
    assign s_axis_tready = r0;

    always_comb
    begin
        px_next = vsrt_pkg::wide_t'(pos_x) * vsrt_pkg::wide_t'(kx);
        py_next = vsrt_pkg::wide_t'(pos_y) * vsrt_pkg::wide_t'(ky);
        pz_next = vsrt_pkg::wide_t'(pos_z) * vsrt_pkg::wide_t'(kz);
    end

    always_comb
    begin
        tx_next = vsrt_pkg::sat32(vsrt_pkg::wide_t'(rz_x)
                                  + vsrt_pkg::wide_t'($signed(offset_x_reg)));
        ty_next = vsrt_pkg::sat32(vsrt_pkg::wide_t'(rz_y)
                                  + vsrt_pkg::wide_t'($signed(offset_y_reg)));
        tz_next = vsrt_pkg::sat32(vsrt_pkg::wide_t'(rz_z)
                                  + vsrt_pkg::wide_t'($signed(offset_z_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vt_reg <= 1'b0;
        end
        else
        begin
            if (r0)
            begin
                v0_reg <= s_axis_tvalid;
            end
            if (r1)
            begin
                v1_reg <= v0_reg;
            end
            if (rt)
            begin
                vt_reg <= rz_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r0 && s_axis_tvalid)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
        if (r1 && v0_reg)
        begin
            sx_reg <= vsrt_pkg::sat32(px_reg >>> 8);
            sy_reg <= vsrt_pkg::sat32(py_reg >>> 8);
            sz_reg <= vsrt_pkg::sat32(pz_reg >>> 8);
        end
        if (rt && rz_valid)
        begin
            tx_reg <= tx_next;
            ty_reg <= ty_next;
            tz_reg <= tz_next;
        end
    end

    // The Y rotation has the opposite handedness, so its stage adds the sine term
    // to the first lane and subtracts it from the second.
    vsrt_rot_stage u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (rotate_enable_reg[0]),
        .flip      (1'b0),
        .sin_val   ($signed(sincos_x_reg[31:16])),
        .cos_val   ($signed(sincos_x_reg[15:0])),
        .in_valid  (v1_reg),
        .in_ready  (rx_in_ready),
        .in_a      (sy_reg),
        .in_b      (sz_reg),
        .in_p      (sx_reg),
        .out_valid (rx_valid),
        .out_ready (ry_in_ready),
        .out_a     (rx_y),
        .out_b     (rx_z),
        .out_p     (rx_x)
    );

    vsrt_rot_stage u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (rotate_enable_reg[1]),
        .flip      (1'b1),
        .sin_val   ($signed(sincos_y_reg[31:16])),
        .cos_val   ($signed(sincos_y_reg[15:0])),
        .in_valid  (rx_valid),
        .in_ready  (ry_in_ready),
        .in_a      (rx_x),
        .in_b      (rx_z),
        .in_p      (rx_y),
        .out_valid (ry_valid),
        .out_ready (rz_in_ready),
        .out_a     (ry_x),
        .out_b     (ry_z),
        .out_p     (ry_y)
    );

    vsrt_rot_stage u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (rotate_enable_reg[2]),
        .flip      (1'b0),
        .sin_val   ($signed(sincos_z_reg[31:16])),
        .cos_val   ($signed(sincos_z_reg[15:0])),
        .in_valid  (ry_valid),
        .in_ready  (rz_in_ready),
        .in_a      (ry_x),
        .in_b      (ry_y),
        .in_p      (ry_z),
        .out_valid (rz_valid),
        .out_ready (rt),
        .out_a     (rz_x),
        .out_b     (rz_y),
        .out_p     (rz_z)
    );

    assign m_axis_tvalid = vt_reg;
    assign m_axis_tdata  = {tz_reg, ty_reg, tx_reg};

endmodule

`default_nettype wire

[rtl/core/vsrt_rot_stage.sv]
// Two-stage planar rotation: a' = ac - bs, b' = bc + as, or with flip set a' = ac + bs,
// b' = bc - as, with a pass-through lane. Depends on vsrt_pkg for types and saturation.
`default_nettype none

module vsrt_rot_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   flip,
    input  wire logic signed [15:0]     sin_val,
    input  wire logic signed [15:0]     cos_val,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire vsrt_pkg::coord_t       in_a,
    input  wire vsrt_pkg::coord_t       in_b,
    input  wire vsrt_pkg::coord_t       in_p,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      vsrt_pkg::coord_t       out_a,
    output      vsrt_pkg::coord_t       out_b,
    output      vsrt_pkg::coord_t       out_p
);

    // Product stage.
    logic             m_valid_reg;
    vsrt_pkg::wide_t  pac_reg, pbs_reg, pas_reg, pbc_reg;
    vsrt_pkg::wide_t  pac_next, pbs_next, pas_next, pbc_next;
    vsrt_pkg::coord_t ma_reg, mb_reg, mp_reg;

    // Shift, sum and clamp stage.
    logic             s_valid_reg;
    vsrt_pkg::coord_t sa_reg, sb_reg, sp_reg;
    vsrt_pkg::coord_t sa_next, sb_next;
    vsrt_pkg::wide_t  sum_a, sum_b;

    logic m_ready, s_ready;

    assign s_ready  = !s_valid_reg || out_ready;
    assign m_ready  = !m_valid_reg || s_ready;
    assign in_ready = m_ready;

    always_comb
    begin
        pac_next = vsrt_pkg::wide_t'(in_a) * vsrt_pkg::wide_t'(cos_val);
        pbs_next = vsrt_pkg::wide_t'(in_b) * vsrt_pkg::wide_t'(sin_val);
        pas_next = vsrt_pkg::wide_t'(in_a) * vsrt_pkg::wide_t'(sin_val);
        pbc_next = vsrt_pkg::wide_t'(in_b) * vsrt_pkg::wide_t'(cos_val);
    end

    // Each product is shifted on its own before the sum, so the sign of a sine term
    // is applied after its rounding.
    always_comb
    begin
        if (flip)
        begin
            sum_a = (pac_reg >>> 14) + (pbs_reg >>> 14);
            sum_b = (pbc_reg >>> 14) - (pas_reg >>> 14);
        end
        else
        begin
            sum_a = (pac_reg >>> 14) - (pbs_reg >>> 14);
            sum_b = (pbc_reg >>> 14) + (pas_reg >>> 14);
        end
        if (en)
        begin
            sa_next = vsrt_pkg::sat32(sum_a);
            sb_next = vsrt_pkg::sat32(sum_b);
        end
        else
        begin
            sa_next = ma_reg;
            sb_next = mb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
            begin
                m_valid_reg <= in_valid;
            end
            if (s_ready)
            begin
                s_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_ready && in_valid)
        begin
            pac_reg <= pac_next;
            pbs_reg <= pbs_next;
            pas_reg <= pas_next;
            pbc_reg <= pbc_next;
            ma_reg  <= in_a;
            mb_reg  <= in_b;
            mp_reg  <= in_p;
        end
        if (s_ready && m_valid_reg)
        begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
            sp_reg <= mp_reg;
        end
    end

    assign out_valid = s_valid_reg;
    assign out_a     = sa_reg;
    assign out_b     = sb_reg;
    assign out_p     = sp_reg;

endmodule

`default_nettype wire

[rtl/core/vsrt_checker.sv]
// Port-level checker for the vertex scale/rotate/translate core, bound to the top level.
// Depends on the core's port list only.
`default_nettype none

module vsrt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata
);

    localparam int unsigned Depth = 9;

    // Beats accepted but not yet delivered.
    logic [3:0] inflight_reg, inflight_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat)
        begin
            inflight_next = inflight_reg + 4'd1;
        end
        else if (out_beat && !in_beat)
        begin
            inflight_next = inflight_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 4'd0)
        else $error("output beat without an outstanding input beat");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(Depth))
        else $error("more beats in flight than pipeline stages");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 4'(Depth) && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while every stage is occupied and stalled");

endmodule

bind vertex_scale_rotate_translate_core vsrt_checker u_vsrt_checker (.*);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for vertex_scale_rotate_translate_core: directed vertices, then
// random register settings and vertices under several idle and stall patterns.
// Depends on vsrt_pkg and the core RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vsrt_pkg::*;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vtx_t;

    typedef struct {
        bit                  is_cfg;
        logic [CfgIdxW-1:0]  idx;
        logic [CfgDataW-1:0] data;
        vtx_t                pos;
        bit                  typed;
        vtx_t                want;
    } dir_row_t;

    localparam coord_t CMAX = coord_t'(32'h7FFF_FFFF);
    localparam coord_t CMIN = coord_t'(32'h8000_0000);
    localparam logic [CfgIdxW-1:0] REG_IDX_SPARE_LO = 8'd8;
    localparam logic [CfgIdxW-1:0] REG_IDX_SPARE_HI = 8'hFF;
    localparam int PIPE_SETTLE   = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int NUM_SEGMENTS  = 16;
    localparam int ITEMS_PER_SEG = 95;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [95:0]         s_axis_tdata = '0;  // pos_x, pos_y, pos_z
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [95:0]         m_axis_tdata;       // out_x, out_y, out_z

    // Shadow copy of the register file, updated when a write beat is accepted.
    logic [31:0] rot_x_sc = SincosReset;
    logic [31:0] rot_y_sc = SincosReset;
    logic [31:0] rot_z_sc = SincosReset;
    logic [47:0] scale_k  = ScaleReset;
    coord_t      off_x    = '0;
    coord_t      off_y    = '0;
    coord_t      off_z    = '0;
    logic [2:0]  rot_en   = '0;

    // Travels with each input beat: a hand-written result overrides the prediction.
    bit   typed_flag = 1'b0;
    vtx_t typed_want = '0;

    vtx_t     expected_pos_q[$];
    dir_row_t dir_rows[$];
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       gap_pct = 0;
    int       stall_pct = 0;
    string    field_tag[3] = '{"out_x", "out_y", "out_z"};

    vertex_scale_rotate_translate_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic vtx_t v3(input coord_t x, input coord_t y, input coord_t z);
        vtx_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > longint'(CMAX))
        begin
            return longint'(CMAX);
        end
        if (v < longint'(CMIN))
        begin
            return longint'(CMIN);
        end
        return v;
    endfunction

    function automatic longint sgn16(input logic [15:0] v);
        logic signed [15:0] t;
        t = v;
        return longint'(t);
    endfunction

    function automatic longint mul_q14(input longint a, input longint k);
        return (a * k) >>> 14;
    endfunction

    // Scale, rotate about X, Y, Z as enabled, then translate, with saturation at each step.
    function automatic vtx_t transform_vertex(input vtx_t p);
        longint x;
        longint y;
        longint z;
        longint a;
        longint b;
        longint s;
        longint c;
        x = clamp32((longint'(p.x) * sgn16(scale_k[15:0])) >>> 8);
        y = clamp32((longint'(p.y) * sgn16(scale_k[31:16])) >>> 8);
        z = clamp32((longint'(p.z) * sgn16(scale_k[47:32])) >>> 8);
        if (rot_en[0])
        begin
            s = sgn16(rot_x_sc[31:16]);
            c = sgn16(rot_x_sc[15:0]);
            a = y;
            b = z;
            y = clamp32(mul_q14(a, c) - mul_q14(b, s));
            z = clamp32(mul_q14(a, s) + mul_q14(b, c));
        end
        if (rot_en[1])
        begin
            s = sgn16(rot_y_sc[31:16]);
            c = sgn16(rot_y_sc[15:0]);
            a = x;
            b = z;
            x = clamp32(mul_q14(a, c) + mul_q14(b, s));
            z = clamp32(mul_q14(b, c) - mul_q14(a, s));
        end
        if (rot_en[2])
        begin
            s = sgn16(rot_z_sc[31:16]);
            c = sgn16(rot_z_sc[15:0]);
            a = x;
            b = y;
            x = clamp32(mul_q14(a, c) - mul_q14(b, s));
            y = clamp32(mul_q14(a, s) + mul_q14(b, c));
        end
        x = clamp32(x + longint'(off_x));
        y = clamp32(y + longint'(off_y));
        z = clamp32(z + longint'(off_z));
        return v3(coord_t'(x), coord_t'(y), coord_t'(z));
    endfunction

    function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] data);
        case (idx)
            REG_SINCOS_X:  rot_x_sc = data[31:0];
            REG_SINCOS_Y:  rot_y_sc = data[31:0];
            REG_SINCOS_Z:  rot_z_sc = data[31:0];
            REG_SCALE_XYZ: scale_k  = data;
            REG_OFFSET_X:  off_x    = data[31:0];
            REG_OFFSET_Y:  off_y    = data[31:0];
            REG_OFFSET_Z:  off_z    = data[31:0];
            REG_ROTATE_EN: rot_en   = data[2:0];
            default: ;
        endcase
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(6))
            0: return CMAX;
            1: return CMIN;
            2: return coord_t'(int'($urandom_range(2)) - 1);
            3, 4: return coord_t'(int'($urandom_range(2097152)) - 1048576);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_trig();
        logic [15:0] s;
        logic [15:0] c;
        case ($urandom_range(3))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(5))
                    0: return 32'h7FFF_7FFF;
                    1: return 32'h8000_8000;
                    2: return 32'h4000_0000;
                    3: return 32'hC000_0000;
                    4: return 32'h0000_C000;
                    default: return SincosReset;
                endcase
            end
            default:
            begin
                s = 16'(int'($urandom_range(32768)) - 16384);
                c = 16'(int'($urandom_range(32768)) - 16384);
                return {s, c};
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(5))
            0: return 16'h0100;
            1: return 16'hFF00;
            2: return ($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000;
            3: return 16'($urandom);
            default: return 16'(int'($urandom_range(1024)) - 512);
        endcase
    endfunction

    // Upper bits of the 32-bit registers carry junk; the block must drop them.
    function automatic logic [CfgDataW-1:0] rand_reg_value(input logic [CfgIdxW-1:0] idx);
        case (idx)
            REG_SINCOS_X, REG_SINCOS_Y, REG_SINCOS_Z:
                return {16'($urandom), pick_trig()};
            REG_SCALE_XYZ:
                return {pick_scale(), pick_scale(), pick_scale()};
            REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z:
                return {16'($urandom), pick_coord()};
            default:
                return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic void add_cfg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_vtx(input vtx_t pos, input bit typed, input vtx_t want);
        dir_row_t r;
        r = '{default: '0};
        r.pos = pos;
        r.typed = typed;
        r.want = want;
        dir_rows = {dir_rows, r};
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic push_vertex(input vtx_t pos, input bit typed, input vtx_t want);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pos;
        typed_flag    <= typed;
        typed_want    <= want;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Leaves cfg_valid high so that back-to-back writes never toggle it within one step.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every predicted vertex has come out and the pipe is empty.
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_pos_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        vtx_t want;
        vtx_t got;
        bit   moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                expected_pos_q = {expected_pos_q,
                                  (typed_flag ? typed_want
                                              : transform_vertex(vtx_t'(s_axis_tdata)))};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                got = vtx_t'(m_axis_tdata);
                if (expected_pos_q.size() == 0)
                begin
                    flag_error($sformatf("output beat %h with nothing expected", got));
                end
                else
                begin
                    want = expected_pos_q.pop_front();
                    for (int f = 0; f < 3; f++)
                    begin
                        if (got[f*32 +: 32] !== want[f*32 +: 32])
                        begin
                            flag_error($sformatf("%s expected %h, got %h", field_tag[f],
                                                 want[f*32 +: 32], got[f*32 +: 32]));
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                apply_reg(cfg_index, cfg_data);
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        bit cfg_open;
        cfg_open = 1'b0;

        // Identity transform after reset: every vertex comes out unchanged.
        add_vtx(v3(0, 0, 0), 1'b1, v3(0, 0, 0));
        add_vtx(v3(CMAX, CMIN, -1), 1'b1, v3(CMAX, CMIN, -1));
        add_vtx(v3(CMIN, CMAX, 1), 1'b1, v3(CMIN, CMAX, 1));
        add_vtx(v3(32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA), 1'b1,
                v3(32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA));
        // Largest and smallest scale factors, saturating in the scale stage, then a zero scale.
        add_cfg(REG_SCALE_XYZ, 48'h7FFF_7FFF_7FFF);
        add_vtx(v3(CMAX, CMIN, 32'h0001_0000), 1'b1, v3(CMAX, CMIN, 32'h007F_FF00));
        add_cfg(REG_SCALE_XYZ, 48'h8000_8000_8000);
        add_vtx(v3(CMAX, CMIN, 1), 1'b1, v3(CMIN, CMAX, 32'hFFFF_FF80));
        add_cfg(REG_SCALE_XYZ, 48'h0);
        add_vtx(v3(CMAX, CMIN, 32'h1234_5678), 1'b1, v3(0, 0, 0));
        // Half scale: the shift rounds toward minus infinity.
        add_cfg(REG_SCALE_XYZ, 48'h0080_0080_0080);
        add_vtx(v3(-1, 1, -3), 1'b1, v3(-1, 0, -2));
        // Offsets at the extremes, junk above bit 31 dropped.
        add_cfg(REG_SCALE_XYZ, ScaleReset);
        add_cfg(REG_OFFSET_X, {16'h0000, CMAX});
        add_cfg(REG_OFFSET_Y, {16'hFFFF, CMIN});
        add_cfg(REG_OFFSET_Z, 48'hABCD_0000_0001);
        add_vtx(v3(1, -1, CMAX), 1'b1, v3(CMAX, CMIN, CMAX));
        add_vtx(v3(CMIN, CMAX, -5), 1'b1, v3(-1, -1, -4));
        // Writes to indexes past the last register change nothing.
        add_cfg(REG_IDX_SPARE_LO, 48'h0);
        add_cfg(REG_IDX_SPARE_HI, 48'h0);
        add_vtx(v3(0, 0, 0), 1'b1, v3(CMAX, CMIN, 1));
        add_cfg(REG_OFFSET_X, 48'h0);
        add_cfg(REG_OFFSET_Y, 48'h0);
        add_cfg(REG_OFFSET_Z, 48'h0);
        // Quarter turns about each axis alone.
        add_cfg(REG_SINCOS_X, 48'h0000_4000_0000);
        add_cfg(REG_ROTATE_EN, 48'hFFFF_FFFF_FFF9);
        add_vtx(v3(3, 32'h0001_0000, 32'h0002_0000), 1'b1,
                v3(3, 32'hFFFE_0000, 32'h0001_0000));
        add_cfg(REG_SINCOS_Y, 48'h0000_4000_0000);
        add_cfg(REG_ROTATE_EN, 48'h2);
        add_vtx(v3(32'h0001_0000, 5, 32'h0002_0000), 1'b1,
                v3(32'h0002_0000, 5, 32'hFFFF_0000));
        add_cfg(REG_SINCOS_Z, 48'h1234_4000_0000);
        add_cfg(REG_ROTATE_EN, 48'h4);
        add_vtx(v3(32'h0001_0000, 32'h0002_0000, 7), 1'b1,
                v3(32'hFFFE_0000, 32'h0001_0000, 7));
        // All three rotations with unnormalized sine and cosine.
        add_cfg(REG_SINCOS_X, 48'h0000_8000_8000);
        add_cfg(REG_SINCOS_Y, 48'h0000_8000_8000);
        add_cfg(REG_SINCOS_Z, 48'h0000_8000_8000);
        add_cfg(REG_ROTATE_EN, 48'h7);
        add_vtx(v3(CMAX, CMIN, CMAX), 1'b0, '0);
        add_vtx(v3(32'h0001_8000, 32'hFFFD_0000, 1), 1'b0, '0);
        add_cfg(REG_SINCOS_X, 48'h0000_7FFF_7FFF);
        add_cfg(REG_SINCOS_Y, 48'h0000_7FFF_7FFF);
        add_cfg(REG_SINCOS_Z, 48'h0000_7FFF_7FFF);
        add_vtx(v3(CMIN, CMIN, CMIN), 1'b0, '0);
        add_vtx(v3(-1, -1, -1), 1'b0, '0);
        add_vtx(v3(CMAX, 32'h0000_C000, CMIN), 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                if (!cfg_open)
                begin
                    drain_pipe();
                end
                write_reg(dir_rows[i].idx, dir_rows[i].data);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_release();
                    cfg_open = 1'b0;
                end
                push_vertex(dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    gap_pct = 26;
                    stall_pct = 26;
                end
            endcase
            drain_pipe();
            for (int r = REG_SINCOS_X; r <= REG_ROTATE_EN; r++)
            begin
                write_reg(CfgIdxW'(r), rand_reg_value(CfgIdxW'(r)));
            end
            if ($urandom_range(2) == 0)
            begin
                write_reg(($urandom_range(1) == 0) ? REG_IDX_SPARE_LO : REG_IDX_SPARE_HI,
                          rand_reg_value(REG_IDX_SPARE_HI));
            end
            cfg_release();
            for (int n = 0; n < ITEMS_PER_SEG; n++)
            begin
                push_vertex(v3(pick_coord(), pick_coord(), pick_coord()), 1'b0, '0);
            end
        end

        drain_pipe();
        if (mismatches == 0 && expected_pos_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
